>>> design/pid_esc_throttle_macros.svh
// Assertion helpers included by pid_esc_throttle.sv.
`ifndef PID_ESC_THROTTLE_MACROS_SVH
`define PID_ESC_THROTTLE_MACROS_SVH

// Check a consequence in the same cycle.
`define PET_AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define PET_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pet_pkg.sv
`timescale 1ns / 1ps
package pet_pkg;

  localparam int MUL_W  = 48;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_N  = 72;
  localparam int DIV_D  = 32;
  localparam int TERM_W = 66;

  localparam logic [7:0] REG_SETPOINT   = 8'd0;
  localparam logic [7:0] REG_GAIN_PROP  = 8'd1;
  localparam logic [7:0] REG_GAIN_INTEG = 8'd2;
  localparam logic [7:0] REG_GAIN_DERIV = 8'd3;

  localparam logic [1:0] MODE_ZERO  = 2'd0;
  localparam logic [1:0] MODE_PROP  = 2'd1;
  localparam logic [1:0] MODE_ONOFF = 2'd2;
  localparam logic [1:0] MODE_PID   = 2'd3;

  localparam logic [MUL_W-1:0] PULSE_BASE = 48'd65536000;
  localparam logic [MUL_W-1:0] MS_SCALE   = 48'd1000;
  localparam logic [DIV_D-1:0] I_DIVISOR  = 32'd1000;
  localparam logic [DIV_N-1:0] I_ROUND    = 72'd500;
  localparam logic [DIV_D-1:0] DUTY_DEN   = 32'd1310720000;
  localparam logic [DIV_N-1:0] DUTY_HALF  = 72'd655360000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MP,
    ST_MEL,
    ST_MI,
    ST_DI,
    ST_MD1,
    ST_MD2,
    ST_DD,
    ST_SUM,
    ST_MV,
    ST_MDUTY,
    ST_DDUTY,
    ST_OUT
  } pet_state_t;

  function automatic logic signed [TERM_W-1:0] pet_sign(input logic [TERM_W-1:0] m,
                                                         input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> design/pet_mul.sv
`timescale 1ns / 1ps
module pet_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pet_pkg::MUL_W-1:0]       a,
  input  logic [pet_pkg::MUL_W-1:0]       b,
  output logic                            busy,
  output logic                            done,
  output logic [pet_pkg::PROD_W-1:0]      p
);
  import pet_pkg::*;

  localparam int CW = $clog2(MUL_W);

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [MUL_W:0] hi_r, hi_nxt;
  logic [MUL_W-1:0] lo_r, lo_nxt;
  logic [MUL_W-1:0] a_r, a_nxt;
  logic [MUL_W:0] sum;

  // Shift-add, one multiplier bit per cycle.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    sum      = hi_r + (lo_r[0] ? {1'b0, a_r} : '0);
    if (start) begin
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = {1'b0, sum[MUL_W:1]};
      lo_nxt  = {sum[0], lo_r[MUL_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MUL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    a_r  <= a_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = {hi_r[MUL_W-1:0], lo_r};
endmodule

>>> design/pet_div.sv
`timescale 1ns / 1ps
module pet_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pet_pkg::DIV_N-1:0]     dividend,
  input  logic [pet_pkg::DIV_D-1:0]     divisor,
  output logic                          busy,
  output logic                          done,
  output logic [pet_pkg::DIV_N-1:0]     q
);
  import pet_pkg::*;

  localparam int CW = $clog2(DIV_N);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_D-1:0] rem_r, rem_nxt;
  logic [DIV_N-1:0] quo_r, quo_nxt;
  logic [DIV_D-1:0] den_r, den_nxt;
  logic [DIV_D:0]   trial;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[DIV_N-1]};
    ge       = trial >= {1'b0, den_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_D'(trial - {1'b0, den_r}) : trial[DIV_D-1:0];
      quo_nxt = {quo_r[DIV_N-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign q    = quo_r;
endmodule

>>> design/pid_esc_throttle.sv
`timescale 1ns / 1ps
// channel | direction | tdata (low bit up)       | tuser
// in_     | slave     | sample, elapsed_ms       | mode, run
// out_    | master    | duty, control_value      | -
// cfg_    | slave     | cfg_addr index, cfg_data | -
// One word at a time: a word is taken only in the idle state, after the last result has gone to the
// output register. run=0 and modes 0/2 do only the duty steps, mode 1 adds the proportional multiply,
// mode 3 adds the integral and derivative terms (no derivative with elapsed_ms = 0). Each multiply runs
// 48 bit steps and each divide 72; each bit-serial unit is shared by all steps that use it.
// Reset (rst_n low, synchronous) loads default gains and clears the setpoint, the control state and out_tvalid.
// A new word is taken while a finished result waits; the next result waits
// for out_tready.
module pid_esc_throttle #(
  parameter int DUTY_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((SAMPLE_BITS+16+7)/8)*8-1:0] in_tdata,  // sample, elapsed_ms
  input  logic [2:0] in_tuser,                            // mode, run
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((DUTY_BITS+32+7)/8)*8-1:0] out_tdata,   // duty, control_value
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_addr,
  input  logic [31:0] cfg_data
);
  import pet_pkg::*;
  `include "pid_esc_throttle_macros.svh"

  localparam int SB = SAMPLE_BITS;
  localparam int DB = DUTY_BITS;
  localparam int OW = ((DB + 32 + 7) / 8) * 8;
  localparam logic [MUL_W-1:0] MAXD = MUL_W'((64'd1 << DB) - 64'd1);

  pet_state_t state_r, state_nxt;
  logic launched_r, launched_nxt;

  logic signed [SB-1:0] setpoint_r;
  logic signed [15:0]   gp_r, gi_r, gd_r;
  logic signed [47:0]   integ_r, integ_nxt;
  logic signed [SB:0]   cur_r, cur_nxt, prev_r, prev_nxt;
  logic                 was_r, was_nxt;
  logic [SB-1:0]        sample_r, sample_nxt;
  logic [15:0]          el_r, el_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 run_r, run_nxt;
  logic signed [TERM_W-1:0] p_r, p_nxt, i_r, i_nxt, d_r, d_nxt;
  logic signed [31:0]   ctrl_r, ctrl_nxt;
  logic [DB-1:0]        duty_r, duty_nxt;
  logic [DB-1:0]        out_duty_r, out_duty_nxt;
  logic [31:0]          out_ctrl_r, out_ctrl_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 div_start, div_busy, div_done;
  logic [DIV_N-1:0]     div_n, div_q;
  logic [DIV_D-1:0]     div_d;

  logic signed [SB:0]   err;
  logic signed [SB+1:0] derr;
  logic [SB:0]          err_mag;
  logic [SB+1:0]        derr_mag;
  logic [15:0]          gp_mag, gi_mag, gd_mag;
  logic [47:0]          acc_mag;
  logic signed [49:0]   acc_sum;
  logic signed [TERM_W-1:0] total;
  logic [16:0]          v;
  logic                 is_mul, is_div, unit_done;

  pet_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .p(mul_p)
  );

  pet_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .done(div_done), .q(div_q)
  );

  assign err      = $signed({setpoint_r[SB-1], setpoint_r}) - $signed({sample_r[SB-1], sample_r});
  assign derr     = $signed({cur_r[SB], cur_r}) - $signed({prev_r[SB], prev_r});
  assign err_mag  = cur_r[SB] ? (SB+1)'(-cur_r) : cur_r;
  assign derr_mag = derr[SB+1] ? (SB+2)'(-derr) : derr;
  assign gp_mag   = gp_r[15] ? 16'(-gp_r) : gp_r;
  assign gi_mag   = gi_r[15] ? 16'(-gi_r) : gi_r;
  assign gd_mag   = gd_r[15] ? 16'(-gd_r) : gd_r;
  assign acc_mag  = integ_r[47] ? 48'(-integ_r) : integ_r;
  assign acc_sum  = $signed({{2{integ_r[47]}}, integ_r})
                  + (cur_r[SB] ? -$signed({2'b0, mul_p[47:0]}) : $signed({2'b0, mul_p[47:0]}));
  assign total    = p_r + i_r + d_r;
  assign v        = ctrl_r[31] ? 17'd0 : ((ctrl_r > 32'sd65536) ? 17'd65536 : ctrl_r[16:0]);

  // Operand select for the shared units.
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = DUTY_DEN;
    unique case (state_r)
      ST_MP:    begin is_mul = 1'b1; mul_a = MUL_W'(gp_mag); mul_b = MUL_W'(err_mag); end
      ST_MEL:   begin is_mul = 1'b1; mul_a = MUL_W'(err_mag); mul_b = MUL_W'(el_r); end
      ST_MI:    begin is_mul = 1'b1; mul_a = MUL_W'(gi_mag); mul_b = acc_mag; end
      ST_MD1:   begin is_mul = 1'b1; mul_a = MUL_W'(gd_mag); mul_b = MUL_W'(derr_mag); end
      ST_MD2:   begin is_mul = 1'b1; mul_a = mul_p[MUL_W-1:0]; mul_b = MS_SCALE; end
      ST_MV:    begin is_mul = 1'b1; mul_a = MUL_W'(v); mul_b = MS_SCALE; end
      ST_MDUTY: begin is_mul = 1'b1; mul_a = PULSE_BASE + mul_p[MUL_W-1:0]; mul_b = MAXD; end
      ST_DI: begin
        is_div = 1'b1;
        div_n  = {mul_p[63:0], 8'd0} + I_ROUND;
        div_d  = I_DIVISOR;
      end
      ST_DD: begin
        is_div = 1'b1;
        div_n  = {mul_p[63:0], 8'd0} + DIV_N'(el_r[15:1]);
        div_d  = DIV_D'(el_r);
      end
      ST_DDUTY: begin
        is_div = 1'b1;
        div_n  = mul_p[DIV_N-1:0] + DUTY_HALF;
        div_d  = DUTY_DEN;
      end
      default: ;
    endcase
  end

  assign mul_start = is_mul && !launched_r;
  assign div_start = is_div && !launched_r;
  assign unit_done = (is_mul && mul_done) || (is_div && div_done);

  always_comb begin
    state_nxt     = state_r;
    launched_nxt  = launched_r;
    integ_nxt     = integ_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    was_nxt       = was_r;
    sample_nxt    = sample_r;
    el_nxt        = el_r;
    mode_nxt      = mode_r;
    run_nxt       = run_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    d_nxt         = d_r;
    ctrl_nxt      = ctrl_r;
    duty_nxt      = duty_r;
    out_duty_nxt  = out_duty_r;
    out_ctrl_nxt  = out_ctrl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = (state_r == ST_IDLE);

    if (mul_start || div_start) launched_nxt = 1'b1;
    if (unit_done) launched_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SB-1:0];
          el_nxt     = in_tdata[SB+15:SB];
          mode_nxt   = in_tuser[1:0];
          run_nxt    = in_tuser[2];
          state_nxt  = ST_ERR;
        end
      end
      ST_ERR: begin
        p_nxt    = '0;
        i_nxt    = '0;
        d_nxt    = '0;
        ctrl_nxt = '0;
        if (!run_r) begin
          was_nxt   = 1'b0;
          state_nxt = ST_MV;
        end else begin
          was_nxt  = 1'b1;
          if (!was_r) integ_nxt = '0;
          prev_nxt = cur_r;
          cur_nxt  = err;
          case (mode_r) inside
            MODE_ONOFF: begin
              ctrl_nxt  = (err > 0) ? 32'sd65536 : 32'sd0;
              state_nxt = ST_MV;
            end
            MODE_PROP, MODE_PID: state_nxt = ST_MP;
            default: state_nxt = ST_MV;
          endcase
        end
      end
      ST_MP: begin
        if (mul_done) begin
          p_nxt     = pet_sign(TERM_W'({mul_p[47:0], 8'd0}), gp_r[15] ^ cur_r[SB]);
          state_nxt = (mode_r == MODE_PID) ? ST_MEL : ST_SUM;
        end
      end
      ST_MEL: begin
        if (mul_done) begin
          if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) begin
            integ_nxt = acc_sum[47:0];
          end else begin
            integ_nxt = acc_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end
          state_nxt = ST_MI;
        end
      end
      ST_MI: if (mul_done) state_nxt = ST_DI;
      ST_DI: begin
        if (div_done) begin
          i_nxt     = pet_sign(TERM_W'(div_q), gi_r[15] ^ integ_r[47]);
          state_nxt = (el_r == 16'd0) ? ST_SUM : ST_MD1;
        end
      end
      ST_MD1: if (mul_done) state_nxt = ST_MD2;
      ST_MD2: if (mul_done) state_nxt = ST_DD;
      ST_DD: begin
        if (div_done) begin
          d_nxt     = pet_sign(TERM_W'(div_q), gd_r[15] ^ derr[SB+1]);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (total > TERM_W'(64'sd2147483647)) ctrl_nxt = 32'sh7fffffff;
        else if (total < -TERM_W'(64'sd2147483648)) ctrl_nxt = 32'sh80000000;
        else ctrl_nxt = total[31:0];
        state_nxt = ST_MV;
      end
      ST_MV:    if (mul_done) state_nxt = ST_MDUTY;
      ST_MDUTY: if (mul_done) state_nxt = ST_DDUTY;
      ST_DDUTY: begin
        if (div_done) begin
          duty_nxt  = div_q[DB-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_duty_nxt  = duty_r;
          out_ctrl_nxt  = ctrl_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      was_r       <= 1'b0;
      setpoint_r  <= '0;
      gp_r        <= 16'sd128;
      gi_r        <= 16'sd26;
      gd_r        <= 16'sd26;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      was_r       <= was_nxt;
      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_SETPOINT:   setpoint_r <= cfg_data[SB-1:0];
          REG_GAIN_PROP:  gp_r <= cfg_data[15:0];
          REG_GAIN_INTEG: gi_r <= cfg_data[15:0];
          REG_GAIN_DERIV: gd_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
    sample_r   <= sample_nxt;
    el_r       <= el_nxt;
    mode_r     <= mode_nxt;
    run_r      <= run_nxt;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    d_r        <= d_nxt;
    ctrl_r     <= ctrl_nxt;
    duty_r     <= duty_nxt;
    out_duty_r <= out_duty_nxt;
    out_ctrl_r <= out_ctrl_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'({out_ctrl_r, out_duty_r});

  `PET_AST_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "word accepted while a step is in flight")
  `PET_AST_SAME(a_units_exclusive, mul_busy, !div_busy,
    "multiplier and divider busy together")
  `PET_AST_NEXT(a_result_waits, state_r == ST_OUT && out_valid_r && !out_tready,
    state_r == ST_OUT, "result dropped while output stalled")
endmodule

>>> tb/pid_esc_throttle_test.sv
`timescale 1ns / 1ps
module pid_esc_throttle_test;
  import pet_pkg::*;

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 1500;

  typedef struct packed {
    logic [15:0] duty;
    logic [31:0] ctrl;
  } esc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  pid_esc_throttle i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint sp_q, kp_q, ki_q, kd_q;
  longint integ_q, err_cur_q, err_prev_q;
  bit was_run_q;
  esc_result_t expected_duty_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic longint clamp32(input longint x);
    return x > I32_MAX ? I32_MAX : (x < I32_MIN ? I32_MIN : x);
  endfunction

  function automatic logic [15:0] duty_of(input longint c);
    longint unsigned v, num, den;
    v = c < 0 ? 0 : (c > 65536 ? 65536 : c);
    den = 64'd65536 * 64'd20000;
    num = (64'd65536000 + 64'd1000 * v) * 64'd65535;
    return 16'((num + den / 2) / den);
  endfunction

  function automatic longint unsigned mag(input longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic esc_result_t throttle_step(input logic signed [15:0] smp,
                                                input logic [15:0] ms,
                                                input logic [1:0] md,
                                                input bit run);
    esc_result_t r;
    longint c, acc, prod, pt, it, dt;
    longint unsigned m, q, rm;
    c = 0;
    if (!run) begin
      was_run_q = 0;
      r.duty = duty_of(0);
      r.ctrl = '0;
      return r;
    end
    if (!was_run_q) begin
      was_run_q = 1;
      integ_q = 0;
    end
    err_prev_q = err_cur_q;
    err_cur_q = sp_q - longint'(smp);
    case (md)
      MODE_PROP: c = clamp32(kp_q * err_cur_q * 256);
      MODE_ONOFF: c = err_cur_q > 0 ? 65536 : 0;
      MODE_PID: begin
        acc = integ_q + err_cur_q * longint'(ms);
        if (acc > ACC_MAX) acc = ACC_MAX;
        if (acc < ACC_MIN) acc = ACC_MIN;
        integ_q = acc;
        pt = kp_q * err_cur_q * 256;
        prod = ki_q * integ_q;
        m = mag(prod);
        q = m / 125;
        rm = m % 125;
        m = q * 32 + (rm * 64 + 125) / 250;
        it = prod < 0 ? -longint'(m) : longint'(m);
        dt = 0;
        if (ms != 0) begin
          prod = kd_q * (err_cur_q - err_prev_q) * 256000;
          m = (mag(prod) + ms / 2) / ms;
          dt = prod < 0 ? -longint'(m) : longint'(m);
        end
        c = clamp32(pt + it + dt);
      end
      default: c = 0;
    endcase
    r.duty = duty_of(c);
    r.ctrl = 32'(c);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // check results
  always @(posedge clk) begin
    esc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_duty_q.size() == 0) begin
        report_mismatch("unexpected word duty", out_tdata[15:0], 0);
      end else begin
        want = expected_duty_q.pop_front();
        if (out_tdata[15:0] !== want.duty)
          report_mismatch("duty", out_tdata[15:0], want.duty);
        if (out_tdata[47:16] !== want.ctrl)
          report_mismatch("control_value", $signed(out_tdata[47:16]), $signed(want.ctrl));
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_sample(input logic [15:0] smp, input logic [15:0] ms,
                             input logic [1:0] md, input bit run);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tdata <= {ms, smp};
    in_tuser <= {run, md};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_duty_q.insert(expected_duty_q.size(), throttle_step(smp, ms, md, run));
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_addr <= idx;
    cfg_data <= {16'h0, val};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SETPOINT: sp_q = longint'($signed(val));
      REG_GAIN_PROP: kp_q = longint'($signed(val));
      REG_GAIN_INTEG: ki_q = longint'($signed(val));
      REG_GAIN_DERIV: kd_q = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    while (expected_duty_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_gains(input logic [15:0] sp, input logic [15:0] kp,
                           input logic [15:0] ki, input logic [15:0] kd);
    drain();
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
  endtask

  task automatic test_directed;
    send_sample(16'sd100, 16'd10, MODE_PID, 1'b0);
    send_sample(16'h8000, 16'hFFFF, MODE_ZERO, 1'b1);
    send_sample(16'h7FFF, 16'd0, MODE_PROP, 1'b1);
    send_sample(16'h8000, 16'd20, MODE_PROP, 1'b1);
    send_sample(16'sd5, 16'd5, MODE_ONOFF, 1'b1);
    send_sample(-16'sd5, 16'd5, MODE_ONOFF, 1'b1);
    send_sample(16'sd0, 16'd5, MODE_ONOFF, 1'b1);
    send_sample(-16'sd200, 16'd10, MODE_PID, 1'b1);
    send_sample(16'sd300, 16'd0, MODE_PID, 1'b1);
    send_sample(16'h8000, 16'hFFFF, MODE_PID, 1'b1);
    send_sample(16'h7FFF, 16'hFFFF, MODE_PID, 1'b1);
    send_sample(16'sd0, 16'd1, MODE_PID, 1'b0);
    send_sample(-16'sd50, 16'd3, MODE_PID, 1'b1);
    set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    for (int i = 0; i < 6; i++) send_sample(16'h8000, 16'hFFFF, MODE_PID, 1'b1);
    send_sample(16'h7FFF, 16'd1, MODE_PID, 1'b1);
    send_sample(16'h8000, 16'd1, MODE_PROP, 1'b1);
    set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    for (int i = 0; i < 3; i++) send_sample(16'h7FFF, 16'hFFFF, MODE_PID, 1'b1);
    drain();
    write_reg(8'd7, 16'h1234);
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    logic [15:0] smp, ms;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    set_gains($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(400)) - 16'd200,
              16'($urandom), $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(60)),
              $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(60)));
    for (int i = 0; i < n; i++) begin
      smp = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1000)) - 16'd500;
      ms = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(50));
      send_sample(smp, ms, 2'($urandom), $urandom_range(15) != 0);
    end
  endtask

  initial begin
    sp_q = 0; kp_q = 128; ki_q = 26; kd_q = 26;
    integ_q = 0; err_cur_q = 0; err_prev_q = 0; was_run_q = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 71, 0);
    test_random(200, 0, 71);
    test_random(200, 9, 9);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
